// ===== sv/vgmcsp_pkg.sv =====
// Shared types and constants for the VGM command stream player.
// No dependencies; imported by every module of the block.
package vgmcsp_pkg;

	localparam int WAIT_W = 26;
	localparam int LOAD_W = 24;
	localparam int TPS_W  = 10;

	// result kinds
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_TIMER  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_TICKS_PER_SAMPLE = 2'd0;
	localparam logic [1:0] CFG_FRAME_WAIT_60HZ  = 2'd1;
	localparam logic [1:0] CFG_FRAME_WAIT_50HZ  = 2'd2;

	// command bytes
	localparam logic [7:0] CMD_WRITE_A  = 8'h5A;
	localparam logic [7:0] CMD_WRITE_E  = 8'h5E;
	localparam logic [7:0] CMD_WRITE_P1 = 8'h5F;
	localparam logic [7:0] CMD_WAIT     = 8'h61;
	localparam logic [7:0] CMD_WAIT_60  = 8'h62;
	localparam logic [7:0] CMD_WAIT_50  = 8'h63;
	localparam logic [7:0] CMD_END      = 8'h66;

	localparam logic [8:0] PORT1_BASE = 9'h100;

	localparam logic [TPS_W-1:0]  TPS_RESET    = 10'd570;
	localparam logic [LOAD_W-1:0] FRAME60_RESET = 24'h66666;
	localparam logic [LOAD_W-1:0] FRAME50_RESET = 24'h7AE15;

	typedef struct packed {
		logic [7:0]        cmd;
		logic [1:0]        args;
		logic [7:0]        first_arg;
		logic [WAIT_W-1:0] remaining;
		logic              waiting;
		logic              ended;
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [8:0]        chip_register;
		logic [7:0]        chip_data;
		logic [LOAD_W-1:0] timer_load;
	} result_t;

	// argument bytes skipped after a command that is not decoded
	function automatic logic [1:0] skip_count(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if (b == 8'h31 || b == 8'h4F || b == 8'h50)
			n = 2'd1;
		else if (b == 8'h40 || (b >= 8'h51 && b <= 8'h5D) || b == 8'hA0 ||
			(b >= 8'hB0 && b <= 8'hC8))
			n = 2'd2;
		else if (b >= 8'hD0 && b <= 8'hD6)
			n = 2'd3;
		return n;
	endfunction

endpackage

// ===== sv/vgmcsp_decode.sv =====
// Next-state and result logic for one transaction of the VGM player.
// Depends on vgmcsp_pkg.
module vgmcsp_decode #(
	parameter int unsigned TIMER_MAX = 16777215
) (
	input  vgmcsp_pkg::state_t                  st,
	input  logic                                operation,
	input  logic [7:0]                          stream_byte,
	input  logic [vgmcsp_pkg::TPS_W-1:0]        ticks_per_sample,
	input  logic [vgmcsp_pkg::LOAD_W-1:0]       frame_wait_60hz,
	input  logic [vgmcsp_pkg::LOAD_W-1:0]       frame_wait_50hz,
	output vgmcsp_pkg::state_t                  nxt,
	output logic                                has_result,
	output vgmcsp_pkg::result_t                 res
);
	import vgmcsp_pkg::*;

	localparam logic [WAIT_W-1:0] TMAX_W = WAIT_W'(TIMER_MAX);

	logic [WAIT_W-1:0] product;
	logic [WAIT_W-1:0] total;
	logic              over;
	logic [LOAD_W-1:0] slice_load;
	logic [WAIT_W-1:0] slice_rem;
	logic              is_pair;

	// 16-bit sample count times ticks per sample fits in 26 bits
	assign product = WAIT_W'({stream_byte, st.first_arg}) * WAIT_W'(ticks_per_sample);
	assign total = operation ? st.remaining : product;
	assign over = total > TMAX_W;
	assign slice_load = over ? LOAD_W'(TIMER_MAX) : total[LOAD_W-1:0];
	assign slice_rem = over ? total - TMAX_W : '0;

	assign is_pair = st.cmd == CMD_WRITE_A || st.cmd == CMD_WRITE_E ||
		st.cmd == CMD_WRITE_P1 || st.cmd == CMD_WAIT;

	always_comb begin
		nxt = st;
		has_result = 1'b0;
		res = '0;
		if (operation) begin
			if (st.waiting) begin
				if (st.remaining != '0) begin
					has_result = 1'b1;
					res.kind = KIND_TIMER;
					res.timer_load = slice_load;
					nxt.remaining = slice_rem;
				end else begin
					nxt.waiting = 1'b0;
				end
			end
		end else if (st.waiting || st.ended) begin
			has_result = 1'b1;
			res.kind = KIND_REJECT;
		end else if (st.args != 2'd0) begin
			nxt.args = st.args - 2'd1;
			if (is_pair) begin
				if (st.args == 2'd2) begin
					nxt.first_arg = stream_byte;
				end else if (st.cmd == CMD_WAIT) begin
					has_result = 1'b1;
					res.kind = KIND_TIMER;
					res.timer_load = slice_load;
					nxt.remaining = slice_rem;
					nxt.waiting = 1'b1;
				end else begin
					has_result = 1'b1;
					res.kind = KIND_WRITE;
					res.chip_register = (st.cmd == CMD_WRITE_P1) ?
						(PORT1_BASE | {1'b0, st.first_arg}) : {1'b0, st.first_arg};
					res.chip_data = stream_byte;
				end
			end
		end else begin
			nxt.cmd = stream_byte;
			case (stream_byte)
				CMD_WRITE_A, CMD_WRITE_E, CMD_WRITE_P1, CMD_WAIT: begin
					nxt.args = 2'd2;
				end
				CMD_WAIT_60: begin
					nxt.remaining = '0;
					nxt.waiting = 1'b1;
					has_result = 1'b1;
					res.kind = KIND_TIMER;
					res.timer_load = frame_wait_60hz;
				end
				CMD_WAIT_50: begin
					nxt.remaining = '0;
					nxt.waiting = 1'b1;
					has_result = 1'b1;
					res.kind = KIND_TIMER;
					res.timer_load = frame_wait_50hz;
				end
				CMD_END: begin
					nxt.ended = 1'b1;
					has_result = 1'b1;
					res.kind = KIND_END;
				end
				default: begin
					nxt.args = skip_count(stream_byte);
				end
			endcase
		end
	end

endmodule

// ===== sv/vgm_command_stream_player.sv =====
// VGM command stream player: top level with config, input and result registers.
// A transaction is registered in stage 1, then its result in the result register.
// Throughput: one per cycle if not stalled; in_ready follows out_ready through one level.
// Reset (arst_n low, async) empties both stages, clears the decoder state and
// restores the config registers to their defaults. Depends on vgmcsp_pkg, vgmcsp_decode.
module vgm_command_stream_player #(
	parameter int unsigned TIMER_MAX = 16777215
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [vgmcsp_pkg::LOAD_W-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [7:0]                         stream_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         result_kind,
	output logic [8:0]                         chip_register,
	output logic [7:0]                         chip_data,
	output logic [vgmcsp_pkg::LOAD_W-1:0]      timer_load
);
	import vgmcsp_pkg::*;

	logic [TPS_W-1:0]  tps_q;
	logic [LOAD_W-1:0] f60_q;
	logic [LOAD_W-1:0] f50_q;

	logic       valid_s1;
	logic       operation_s1;
	logic [7:0] byte_s1;

	state_t  state_q;
	state_t  state_nxt;
	logic    has_result;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    fire_s1;

	// stage 1 retires whenever the result register is free or draining
	assign fire_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			f60_q <= FRAME60_RESET;
			f50_q <= FRAME50_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICKS_PER_SAMPLE: tps_q <= cfg_data[TPS_W-1:0];
				CFG_FRAME_WAIT_60HZ:  f60_q <= cfg_data;
				CFG_FRAME_WAIT_50HZ:  f50_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			operation_s1 <= operation;
			byte_s1 <= stream_byte;
		end
	end

	vgmcsp_decode #(
		.TIMER_MAX(TIMER_MAX)
	) u_decode (
		.st               (state_q),
		.operation        (operation_s1),
		.stream_byte      (byte_s1),
		.ticks_per_sample (tps_q),
		.frame_wait_60hz  (f60_q),
		.frame_wait_50hz  (f50_q),
		.nxt              (state_nxt),
		.has_result       (has_result),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1)
				state_q <= state_nxt;
			if (fire_s1)
				out_valid_q <= has_result;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_result)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_q.kind;
	assign chip_register = out_q.chip_register;
	assign chip_data = out_q.chip_data;
	assign timer_load = out_q.timer_load;

endmodule

// ===== sv/vgmcsp_checker.sv =====
// Port-level checks for the VGM command stream player, bound to the top level.
// Depends on vgmcsp_pkg and vgm_command_stream_player.
module vgmcsp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    result_kind,
	input logic [8:0]                    chip_register,
	input logic [7:0]                    chip_data,
	input logic [vgmcsp_pkg::LOAD_W-1:0] timer_load
);
	import vgmcsp_pkg::*;

	// a stalled transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(chip_register) && $stable(chip_data) && $stable(timer_load))
		else $error("result changed while stalled");

	a_chip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_WRITE |-> chip_register == '0 && chip_data == '0)
		else $error("chip fields set on non-write result");

	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_TIMER |-> timer_load == '0)
		else $error("timer load set on non-timer result");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result pending right after reset");

endmodule

bind vgm_command_stream_player vgmcsp_checker u_vgmcsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.result_kind   (result_kind),
	.chip_register (chip_register),
	.chip_data     (chip_data),
	.timer_load    (timer_load)
);

// ===== tb/sv/vgm_command_stream_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the VGM command stream player: watches the config port and both
// channels, predicts each result from a model of the command parser and compares.
// Depends on vgmcsp_pkg.
module vgm_command_stream_checker #(
	parameter int unsigned TIMER_MAX = 16777215
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [vgmcsp_pkg::LOAD_W-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          operation,
	input  logic [7:0]                    stream_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    result_kind,
	input  logic [8:0]                    chip_register,
	input  logic [7:0]                    chip_data,
	input  logic [vgmcsp_pkg::LOAD_W-1:0] timer_load,
	output int                            mismatch_count,
	output int                            pending_results,
	output int                            transactions_in,
	output int                            results_checked
);
	import vgmcsp_pkg::*;

	// commands whose argument bytes are skipped
	localparam logic [7:0] SKIP1_A     = 8'h31;
	localparam logic [7:0] SKIP1_B     = 8'h4F;
	localparam logic [7:0] SKIP1_C     = 8'h50;
	localparam logic [7:0] SKIP2_A     = 8'h40;
	localparam logic [7:0] SKIP2_LOW   = 8'h51;
	localparam logic [7:0] SKIP2_HIGH  = 8'h5D;
	localparam logic [7:0] SKIP2_B     = 8'hA0;
	localparam logic [7:0] SKIP2_RLOW  = 8'hB0;
	localparam logic [7:0] SKIP2_RHIGH = 8'hC8;
	localparam logic [7:0] SKIP3_LOW   = 8'hD0;
	localparam logic [7:0] SKIP3_HIGH  = 8'hD6;

	// parser model
	logic [7:0]        cur_cmd;
	logic [1:0]        args_left;
	logic [7:0]        low_byte;
	logic [WAIT_W-1:0] wait_left;
	logic              timer_busy;
	logic              playback_done;
	logic [TPS_W-1:0]  ticks_per_sample;
	logic [LOAD_W-1:0] frame60;
	logic [LOAD_W-1:0] frame50;

	result_t expected_results[$];
	result_t want;

	function automatic logic [1:0] skipped_arg_bytes(input logic [7:0] code);
		if (code == SKIP1_A || code == SKIP1_B || code == SKIP1_C)
			return 2'd1;
		if (code == SKIP2_A || code == SKIP2_B || (code >= SKIP2_LOW && code <= SKIP2_HIGH) ||
			(code >= SKIP2_RLOW && code <= SKIP2_RHIGH))
			return 2'd2;
		if (code >= SKIP3_LOW && code <= SKIP3_HIGH)
			return 2'd3;
		return 2'd0;
	endfunction

	task automatic push_result(input logic [1:0] kind, input logic [8:0] addr,
		input logic [7:0] data, input logic [LOAD_W-1:0] load);
		result_t r;
		r.kind          = kind;
		r.chip_register = addr;
		r.chip_data     = data;
		r.timer_load    = load;
		expected_results.push_back(r);
	endtask

	// one timer load per expiry; the rest of a long wait is kept for later
	task automatic load_timer(input logic [WAIT_W-1:0] total);
		logic [WAIT_W-1:0] slice;
		slice = (total > WAIT_W'(TIMER_MAX)) ? WAIT_W'(TIMER_MAX) : total;
		wait_left = total - slice;
		timer_busy = 1'b1;
		push_result(KIND_TIMER, '0, '0, slice[LOAD_W-1:0]);
	endtask

	task automatic advance_player(input logic is_expiry, input logic [7:0] b);
		logic [WAIT_W-1:0] samples;
		samples = '0;
		if (is_expiry) begin
			if (timer_busy) begin
				if (wait_left != 0)
					load_timer(wait_left);
				else
					timer_busy = 1'b0;
			end
		end else if (timer_busy || playback_done) begin
			push_result(KIND_REJECT, '0, '0, '0);
		end else if (args_left != 0) begin
			args_left = args_left - 2'd1;
			if (cur_cmd == CMD_WRITE_A || cur_cmd == CMD_WRITE_E ||
				cur_cmd == CMD_WRITE_P1 || cur_cmd == CMD_WAIT) begin
				if (args_left == 2'd1) begin
					low_byte = b;
				end else if (cur_cmd == CMD_WAIT) begin
					samples = {10'd0, b, low_byte};
					load_timer(samples * {16'd0, ticks_per_sample});
				end else if (cur_cmd == CMD_WRITE_P1) begin
					push_result(KIND_WRITE, PORT1_BASE | {1'b0, low_byte}, b, '0);
				end else begin
					push_result(KIND_WRITE, {1'b0, low_byte}, b, '0);
				end
			end
		end else begin
			cur_cmd = b;
			case (b)
				CMD_WRITE_A, CMD_WRITE_E, CMD_WRITE_P1, CMD_WAIT: args_left = 2'd2;
				CMD_WAIT_60, CMD_WAIT_50: begin
					wait_left = '0;
					timer_busy = 1'b1;
					push_result(KIND_TIMER, '0, '0, (b == CMD_WAIT_60) ? frame60 : frame50);
				end
				CMD_END: begin
					playback_done = 1'b1;
					push_result(KIND_END, '0, '0, '0);
				end
				default: args_left = skipped_arg_bytes(b);
			endcase
		end
	endtask

	task automatic compare_field(input string label, input logic [LOAD_W-1:0] expected,
		input logic [LOAD_W-1:0] actual);
		if (expected !== actual) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, label, expected, actual);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cmd          = '0;
			args_left        = '0;
			low_byte         = '0;
			wait_left        = '0;
			timer_busy       = 1'b0;
			playback_done    = 1'b0;
			ticks_per_sample = TPS_RESET;
			frame60          = FRAME60_RESET;
			frame50          = FRAME50_RESET;
			expected_results.delete();
			mismatch_count   = 0;
			pending_results  = 0;
			transactions_in  = 0;
			results_checked  = 0;
		end else begin
			// older expectations first; a new transaction cannot show its result this edge
			if (out_valid && out_ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: unexpected result, expected none, actual kind %0d",
						$time, result_kind);
				end else begin
					want = expected_results.pop_front();
					compare_field("result_kind", LOAD_W'(want.kind), LOAD_W'(result_kind));
					compare_field("chip_register", LOAD_W'(want.chip_register),
						LOAD_W'(chip_register));
					compare_field("chip_data", LOAD_W'(want.chip_data), LOAD_W'(chip_data));
					compare_field("timer_load", want.timer_load, timer_load);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TICKS_PER_SAMPLE: ticks_per_sample = cfg_data[TPS_W-1:0];
					CFG_FRAME_WAIT_60HZ:  frame60 = cfg_data;
					CFG_FRAME_WAIT_50HZ:  frame50 = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				transactions_in++;
				advance_player(operation, stream_byte);
			end
			pending_results = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/vgm_command_stream_player_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the VGM command stream player: drives reset, config writes and the
// byte/timer-event stream with random idling; verdict from vgm_command_stream_checker.
// Depends on vgmcsp_pkg, vgm_command_stream_player, vgm_command_stream_checker.
module vgm_command_stream_player_test;
	import vgmcsp_pkg::*;

	localparam int unsigned TIMER_MAX   = 16777215;
	localparam int          CYCLE_LIMIT = 200000;
	// bytes that are unknown commands, safe both as arguments and as commands
	localparam logic [7:0] PAD_LOW_TOP   = 8'h30;
	localparam logic [7:0] PAD_HIGH_BASE = 8'hE0;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_we      = 1'b0;
	logic [1:0]        cfg_index   = '0;
	logic [LOAD_W-1:0] cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              operation   = 1'b0;
	logic [7:0]        stream_byte = '0;
	logic              out_ready   = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [1:0]        result_kind;
	logic [8:0]        chip_register;
	logic [7:0]        chip_data;
	logic [LOAD_W-1:0] timer_load;

	int mismatch_count;
	int pending_results;
	int transactions_in;
	int results_checked;

	int               items_sent    = 0;
	int               cycle_count   = 0;
	int               out_stall_left = 0;
	bit               idling        = 1'b1;
	logic [TPS_W-1:0] tps_setting   = TPS_RESET;

	vgm_command_stream_player #(.TIMER_MAX(TIMER_MAX)) dut (.*);

	vgm_command_stream_checker #(.TIMER_MAX(TIMER_MAX)) player_checker (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycle_count, pending_results);
			$display("FAILURE");
			$finish;
		end
	end

	// result-side stalls in bursts of random length
	always @(posedge clk) begin
		if (out_stall_left > 0) begin
			out_stall_left <= out_stall_left - 1;
		end else if (idling && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			out_stall_left <= $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// in_ready is sampled at the falling edge, where nothing is changing
	task automatic send_item(input logic is_expiry, input logic [7:0] b);
		logic taken;
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= is_expiry;
		stream_byte <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		items_sent++;
	endtask

	function automatic logic [7:0] pad_byte();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(PAD_HIGH_BASE, 255));
		return 8'($urandom_range(0, PAD_LOW_TOP));
	endfunction

	// one expiry per timer load, sometimes with bytes that must be rejected in between
	task automatic serve_timer(input int loads);
		repeat (loads) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom_range(0, 255)));
			send_item(1'b1, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_command();
		logic [7:0] code;
		logic [7:0] lo;
		logic [7:0] hi;
		int unsigned total;
		case ($urandom_range(0, 5))
			0, 1: case ($urandom_range(0, 2))
				0:       code = CMD_WRITE_A;
				1:       code = CMD_WRITE_E;
				default: code = CMD_WRITE_P1;
			endcase
			2:       code = CMD_WAIT;
			3:       code = $urandom_range(0, 1) ? CMD_WAIT_60 : CMD_WAIT_50;
			default: code = 8'($urandom_range(0, 255));
		endcase
		// end of data is kept for the close of the run
		if (code == CMD_END)
			code = CMD_WAIT_50;
		send_item(1'b0, code);
		if (code == CMD_WRITE_A || code == CMD_WRITE_E || code == CMD_WRITE_P1) begin
			repeat (2) send_item(1'b0, 8'($urandom_range(0, 255)));
		end else if (code == CMD_WAIT) begin
			lo = 8'($urandom_range(0, 255));
			hi = 8'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 3));
			send_item(1'b0, lo);
			send_item(1'b0, hi);
			total = 32'({hi, lo}) * 32'(tps_setting);
			serve_timer(total == 0 ? 1 : (total + TIMER_MAX - 1) / TIMER_MAX);
		end else if (code == CMD_WAIT_60 || code == CMD_WAIT_50) begin
			serve_timer(1);
		end else begin
			// covers up to three skipped arguments, then resyncs
			repeat (3) send_item(1'b0, pad_byte());
		end
		if ($urandom_range(0, 7) == 0)
			send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_until_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_settings(input logic [TPS_W-1:0] tps, input logic [LOAD_W-1:0] f60,
		input logic [LOAD_W-1:0] f50);
		wait_until_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TICKS_PER_SAMPLE;
		cfg_data <= {{(LOAD_W - TPS_W){1'b0}}, tps};
		@(posedge clk);
		cfg_index <= CFG_FRAME_WAIT_60HZ;
		cfg_data <= f60;
		@(posedge clk);
		cfg_index <= CFG_FRAME_WAIT_50HZ;
		cfg_data <= f50;
		@(posedge clk);
		cfg_we <= 1'b0;
		tps_setting = tps;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset settings
		send_item(1'b1, 8'hFF);                 // expiry with no wait running
		send_item(1'b0, 8'h00);                 // unknown command
		send_item(1'b0, CMD_WRITE_A);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b0, CMD_WRITE_P1);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, CMD_WAIT);              // zero samples still loads the timer
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b0, CMD_END);               // rejected while waiting
		send_item(1'b1, 8'h00);
		send_item(1'b0, CMD_WAIT);              // longest wait: three slices
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'hFF);
		repeat (3) send_item(1'b1, 8'h00);
		send_item(1'b0, CMD_WAIT_60);
		send_item(1'b1, 8'h00);
		send_item(1'b0, CMD_WAIT_50);
		send_item(1'b1, 8'h00);

		while (items_sent < 110) random_command();
		load_settings(10'd1023, 24'hFFFFFF, 24'h000000);
		while (items_sent < 210) random_command();
		load_settings(10'd0, 24'h000000, 24'hFFFFFF);
		while (items_sent < 300) random_command();
		load_settings(TPS_W'($urandom_range(0, 1023)), LOAD_W'($urandom_range(0, 24'hFFFFFF)),
			LOAD_W'($urandom_range(0, 24'hFFFFFF)));
		while (items_sent < 400) random_command();
		load_settings(10'd1, 24'd1, 24'h800000);
		idling = 1'b0;
		while (items_sent < 500) random_command();
		send_item(1'b0, CMD_END);
		repeat (4) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		wait_until_idle();

		$display("Covered %0d input transactions and %0d checked results over five settings,",
			transactions_in, results_checked);
		$display("with writes on both ports, sliced and frame waits, rejects and end of data.");
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
